### sv/primitive_collision_test_defines.svh
// Assertion macros shared by the primitive collision test checkers.
`ifndef PRIMITIVE_COLLISION_TEST_DEFINES_SVH
`define PRIMITIVE_COLLISION_TEST_DEFINES_SVH

// Check cons at the same edge as ante.
`define PCOL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons a fixed number of edges after ante.
`define PCOL_ASSERT_LAT(lbl, clk, rst_n, ante, lat, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##lat (cons)) \
        else $error(msg);

`endif

### sv/pcol_pkg.sv
// Shared constants and types for the primitive collision test.
package pcol_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    localparam logic [1:0] KIND_NOCLIP = 2'd0;
    localparam logic [1:0] KIND_SPHERE = 2'd1;
    localparam logic [1:0] KIND_BOX    = 2'd2;

    // Test selected for one pair of primitives.
    typedef enum logic [1:0] {
        PAIR_NONE,
        PAIR_SS,
        PAIR_BB,
        PAIR_BS
    } t_pair;

endpackage

### sv/primitive_collision_test.sv
// Top level of the primitive collision test pipeline.
// A pair taken at an accepting edge shows its hit on o_hit with o_valid high once it has
//   passed the stage registers r_s1, r_s2, r_s3 and then the result register.
// Throughput: one pair per cycle; busy stays low, the four stages never stall.
// Depth is set by the squaring stage (one multiplier per axis plus one for the radius).
// Reset: synchronous, active low; clears the valid bits only, no result beat follows.
module primitive_collision_test #(
    parameter int COORD_WIDTH = pcol_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_first_kind,
    input  logic [1:0]                    i_second_kind,
    input  logic signed [COORD_WIDTH-1:0] i_first_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_y,
    input  logic signed [COORD_WIDTH-1:0] i_first_z,
    input  logic signed [COORD_WIDTH-1:0] i_second_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_z,
    input  logic [3*COORD_WIDTH-1:0]      i_first_extents,
    input  logic [3*COORD_WIDTH-1:0]      i_second_extents,
    output logic                          o_valid,
    output logic                          o_hit
);

    import pcol_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int EW  = 3 * W;
    localparam int SQW = 2 * W + 2;

    // ------------------------------------------------------------------
    // Stage 0: classify the pair, take per-axis centre distances.
    // ------------------------------------------------------------------
    logic           accept;
    logic [W-1:0]   c1 [3];
    logic [W-1:0]   c2 [3];
    logic [W:0]     d [3];
    logic [W:0]     d_neg [3];
    logic [W-1:0]   n_s1_mag [3];
    logic [EW-1:0]  ext1;
    logic [EW-1:0]  ext2;
    t_pair          n_s1_pair;
    logic [EW-1:0]  n_s1_ea;
    logic [EW-1:0]  n_s1_eb;

    // The pipeline never holds off a pair.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign c1[0] = i_first_x;
    assign c1[1] = i_first_y;
    assign c1[2] = i_first_z;
    assign c2[0] = i_second_x;
    assign c2[1] = i_second_y;
    assign c2[2] = i_second_z;

    // Extent bits beyond bit 63 read as zero (matters only for wide coordinates).
    always_comb begin
        for (int i = 0; i < EW; i++) begin
            ext1[i] = (i < 64) ? i_first_extents[i] : 1'b0;
            ext2[i] = (i < 64) ? i_second_extents[i] : 1'b0;
        end
    end

    // |c1 - c2| per axis; fits in W bits since both centres are W-bit signed.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d[k]        = {c1[k][W-1], c1[k]} - {c2[k][W-1], c2[k]};
            d_neg[k]    = -d[k];
            n_s1_mag[k] = d[k][W] ? d_neg[k][W-1:0] : d[k][W-1:0];
        end
    end

    // Pick the test. For box-sphere, steer the box extents into slot a and
    // the sphere extents into slot b, whichever order they came in.
    // Noclip or an unused kind code on either side selects no test.
    always_comb begin
        n_s1_pair = PAIR_NONE;
        n_s1_ea   = ext1;
        n_s1_eb   = ext2;
        if (i_first_kind == KIND_SPHERE && i_second_kind == KIND_SPHERE) begin
            n_s1_pair = PAIR_SS;
        end else if (i_first_kind == KIND_BOX && i_second_kind == KIND_BOX) begin
            n_s1_pair = PAIR_BB;
        end else if (i_first_kind == KIND_BOX && i_second_kind == KIND_SPHERE) begin
            n_s1_pair = PAIR_BS;
        end else if (i_first_kind == KIND_SPHERE && i_second_kind == KIND_BOX) begin
            n_s1_pair = PAIR_BS;
            n_s1_ea   = ext2;
            n_s1_eb   = ext1;
        end
    end

    logic           r_s1_valid;
    t_pair          r_s1_pair;
    logic [W-1:0]   r_s1_mag [3];
    logic [EW-1:0]  r_s1_ea;
    logic [EW-1:0]  r_s1_eb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pair <= n_s1_pair;
        r_s1_mag  <= n_s1_mag;
        r_s1_ea   <= n_s1_ea;
        r_s1_eb   <= n_s1_eb;
    end

    // ------------------------------------------------------------------
    // Stage 1: box overlap per axis, clamp gap for box-sphere, radius.
    // ------------------------------------------------------------------
    logic [W-1:0]   e_a [3];
    logic [W-1:0]   e_b [3];
    logic [W:0]     e_sum [3];
    logic [2:0]     ov;
    logic [W-1:0]   gap [3];
    logic [W-1:0]   n_s2_m [3];
    logic [W:0]     n_s2_r;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e_a[k]   = r_s1_ea[k*W +: W];
            e_b[k]   = r_s1_eb[k*W +: W];
            e_sum[k] = {1'b0, e_a[k]} + {1'b0, e_b[k]};
            // Strict overlap on this axis: touching faces do not count.
            ov[k]    = {1'b0, r_s1_mag[k]} < e_sum[k];
            // Distance from the sphere centre to the box slab, zero inside it.
            gap[k]   = (r_s1_mag[k] > e_a[k]) ? (r_s1_mag[k] - e_a[k]) : '0;
            n_s2_m[k] = (r_s1_pair == PAIR_SS) ? r_s1_mag[k] : gap[k];
        end
        n_s2_r = (r_s1_pair == PAIR_SS) ? e_sum[0] : {1'b0, e_b[0]};
    end

    logic           r_s2_valid;
    t_pair          r_s2_pair;
    logic           r_s2_bb;
    logic [W-1:0]   r_s2_m [3];
    logic [W:0]     r_s2_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_pair <= r_s1_pair;
        r_s2_bb   <= &ov;
        r_s2_m    <= n_s2_m;
        r_s2_r    <= n_s2_r;
    end

    // ------------------------------------------------------------------
    // Stage 2: square the three axis terms and the radius.
    // ------------------------------------------------------------------
    logic [2*W-1:0] sq [3];
    logic [SQW-1:0] rad_sq;

    for (genvar g = 0; g < 3; g++) begin : g_axis_sq
        pcol_square #(
            .IN_W (W)
        ) u_axis_sq (
            .i_clk (i_clk),
            .i_a   (r_s2_m[g]),
            .o_sq  (sq[g])
        );
    end

    pcol_square #(
        .IN_W (W + 1)
    ) u_rad_sq (
        .i_clk (i_clk),
        .i_a   (r_s2_r),
        .o_sq  (rad_sq)
    );

    logic           r_s3_valid;
    t_pair          r_s3_pair;
    logic           r_s3_bb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_pair <= r_s2_pair;
        r_s3_bb   <= r_s2_bb;
    end

    // ------------------------------------------------------------------
    // Stage 3: sum of squares against squared radius, drive the result beat.
    // ------------------------------------------------------------------
    logic [SQW-1:0] dist_sq;
    logic           n_hit;

    assign dist_sq = SQW'(sq[0]) + SQW'(sq[1]) + SQW'(sq[2]);

    always_comb begin
        case (r_s3_pair)
            PAIR_SS, PAIR_BS: n_hit = (dist_sq <= rad_sq);
            PAIR_BB:          n_hit = r_s3_bb;
            default:          n_hit = 1'b0;
        endcase
    end

    logic r_valid;
    logic r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= n_hit;
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;

endmodule

### sv/pcol_square.sv
// Registered unsigned squaring unit.
module pcol_square #(
    parameter int IN_W = 16
) (
    input  logic                i_clk,
    input  logic [IN_W-1:0]     i_a,
    output logic [2*IN_W-1:0]   o_sq
);

    logic [2*IN_W-1:0] n_sq;
    logic [2*IN_W-1:0] r_sq;

    assign n_sq = (2*IN_W)'(i_a) * (2*IN_W)'(i_a);

    always_ff @(posedge i_clk) begin
        r_sq <= n_sq;
    end

    assign o_sq = r_sq;

endmodule

### sv/pcol_checker.sv
// Port-level checker for the primitive collision test, bound to the top level.
`include "primitive_collision_test_defines.svh"

module pcol_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_first_kind,
    input logic [1:0] i_second_kind,
    input logic       o_valid,
    input logic       o_hit
);

    import pcol_pkg::*;

    // Every accepted beat yields exactly one result beat through the pipeline registers.
    `PCOL_ASSERT_LAT(a_lat_fwd, i_clk, i_rst_n, start && !busy, 4, o_valid, "result beat missing")
    `PCOL_ASSERT_NOW(a_lat_back, i_clk, i_rst_n, o_valid,
        $past(start && !busy, 4), "result beat without a pair")
    // A noclip object on either side never collides.
    `PCOL_ASSERT_LAT(a_noclip, i_clk, i_rst_n,
        start && !busy && (i_first_kind == KIND_NOCLIP || i_second_kind == KIND_NOCLIP),
        4, o_valid && !o_hit, "noclip pair reported a hit")

endmodule

bind primitive_collision_test pcol_checker u_pcol_checker (.*);

### tb/sv/primitive_collision_test_tb.sv
// Self-checking testbench for the primitive collision test block.
module primitive_collision_test_tb;
    import pcol_pkg::*;

    localparam int CW            = COORD_WIDTH_DEF;
    localparam int COORD_MAX     = (1 << (CW - 1)) - 1;
    localparam int COORD_MIN     = -(1 << (CW - 1));
    localparam int EXT_MAX       = (1 << CW) - 1;
    localparam int RESET_CYCLES  = 10;
    localparam int DRAIN_CYCLES  = 8;     // extra wait after the last result is checked
    localparam int STALL_LIMIT   = 200;   // cycles with no beat on either side
    localparam int REPORT_LIMIT  = 200;
    localparam int NEAR_PAIRS    = 1100;
    localparam int WIDE_PAIRS    = 700;
    localparam int QUIET_PAIRS   = 300;   // opening stretch with no sender gaps

    // Kind code 3 has no package name; the block treats it as noclip.
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic [3*CW-1:0]      extents_t;
    typedef int                   triple_t [3];

    typedef struct {
        logic [1:0] first_kind;
        logic [1:0] second_kind;
        coord_t     first_c [3];
        coord_t     second_c [3];
        extents_t   first_ext;
        extents_t   second_ext;
    } pair_t;

    typedef struct {
        logic        hit;
        int unsigned index;
    } hit_note_t;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    logic [1:0]     i_first_kind = KIND_NOCLIP;
    logic [1:0]     i_second_kind = KIND_NOCLIP;
    coord_t         i_first_x = '0;
    coord_t         i_first_y = '0;
    coord_t         i_first_z = '0;
    coord_t         i_second_x = '0;
    coord_t         i_second_y = '0;
    coord_t         i_second_z = '0;
    extents_t       i_first_extents = '0;
    extents_t       i_second_extents = '0;
    logic           o_valid;
    logic           o_hit;

    hit_note_t      expected_hits [$];
    int unsigned    pairs_sent = 0;
    int unsigned    results_seen = 0;
    int unsigned    hits_seen = 0;
    int unsigned    mismatch_count = 0;
    int unsigned    stall_cycles = 0;
    int unsigned    test_count [4] = '{0, 0, 0, 0};
    bit             allow_gaps = 1'b0;

    primitive_collision_test #(
        .COORD_WIDTH (CW)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_first_kind     (i_first_kind),
        .i_second_kind    (i_second_kind),
        .i_first_x        (i_first_x),
        .i_first_y        (i_first_y),
        .i_first_z        (i_first_z),
        .i_second_x       (i_second_x),
        .i_second_y       (i_second_y),
        .i_second_z       (i_second_z),
        .i_first_extents  (i_first_extents),
        .i_second_extents (i_second_extents),
        .o_valid          (o_valid),
        .o_hit            (o_hit)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Pick the test that a pair of kinds calls for; anything with noclip or
    // the reserved code gets no test at all.
    function automatic t_pair pair_test(input logic [1:0] ka, input logic [1:0] kb);
        if (ka == KIND_SPHERE && kb == KIND_SPHERE)
            return PAIR_SS;
        if (ka == KIND_BOX && kb == KIND_BOX)
            return PAIR_BB;
        if ((ka == KIND_BOX && kb == KIND_SPHERE) || (ka == KIND_SPHERE && kb == KIND_BOX))
            return PAIR_BS;
        return PAIR_NONE;
    endfunction

    // Exact overlap decision on the fixed-point values. Squares of 17-bit
    // differences fit easily in 64 bits, so nothing needs widening further.
    function automatic logic predict_hit(input pair_t p);
        longint ca [3];
        longint cb [3];
        longint ea [3];
        longint eb [3];
        longint box_c [3];
        longint box_e [3];
        longint sph_c [3];
        longint radius;
        longint dist_sq;
        longint reach;
        longint rel;
        longint gap_len;
        logic   hit;
        hit = 1'b0;
        dist_sq = 0;
        for (int k = 0; k < 3; k++) begin
            ca[k] = longint'(p.first_c[k]);
            cb[k] = longint'(p.second_c[k]);
            ea[k] = longint'(p.first_ext[k*CW +: CW]);
            eb[k] = longint'(p.second_ext[k*CW +: CW]);
        end
        case (pair_test(p.first_kind, p.second_kind))
            PAIR_SS: begin
                for (int k = 0; k < 3; k++)
                    dist_sq += (ca[k] - cb[k]) * (ca[k] - cb[k]);
                reach = ea[0] + eb[0];
                hit = (dist_sq <= reach * reach);
            end
            PAIR_BB: begin
                // Touching faces do not count: both comparisons are strict.
                hit = 1'b1;
                for (int k = 0; k < 3; k++)
                    if (!(cb[k] - eb[k] < ca[k] + ea[k] && cb[k] + eb[k] > ca[k] - ea[k]))
                        hit = 1'b0;
            end
            PAIR_BS: begin
                // Normalize to box first, sphere second, then clamp the
                // sphere centre into the box.
                if (p.first_kind == KIND_BOX) begin
                    box_c = ca;
                    box_e = ea;
                    sph_c = cb;
                    radius = eb[0];
                end else begin
                    box_c = cb;
                    box_e = eb;
                    sph_c = ca;
                    radius = ea[0];
                end
                for (int k = 0; k < 3; k++) begin
                    rel = sph_c[k] - box_c[k];
                    gap_len = 0;
                    if (rel > box_e[k])
                        gap_len = rel - box_e[k];
                    else if (rel < -box_e[k])
                        gap_len = rel + box_e[k];
                    dist_sq += gap_len * gap_len;
                end
                hit = (dist_sq <= radius * radius);
            end
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic pair_t make_pair(input logic [1:0] ka, input logic [1:0] kb,
                                        input triple_t a_c, input triple_t a_e,
                                        input triple_t b_c, input triple_t b_e);
        pair_t p;
        p.first_kind = ka;
        p.second_kind = kb;
        for (int k = 0; k < 3; k++) begin
            p.first_c[k] = coord_t'(a_c[k]);
            p.second_c[k] = coord_t'(b_c[k]);
            p.first_ext[k*CW +: CW] = a_e[k][CW-1:0];
            p.second_ext[k*CW +: CW] = b_e[k][CW-1:0];
        end
        return p;
    endfunction

    function automatic coord_t sat_coord(input int v);
        if (v > COORD_MAX)
            return coord_t'(COORD_MAX);
        if (v < COORD_MIN)
            return coord_t'(COORD_MIN);
        return coord_t'(v);
    endfunction

    function automatic logic [1:0] pick_kind();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return KIND_SPHERE;
        if (roll < 90)
            return KIND_BOX;
        return (roll < 95) ? KIND_NOCLIP : KIND_RESERVED;
    endfunction

    // Extent that a primitive reaches along one axis: spheres use the radius.
    function automatic int reach_along(input logic [1:0] kind, input extents_t ext,
                                       input int ax);
        return (kind == KIND_SPHERE) ? int'(ext[CW-1:0]) : int'(ext[ax*CW +: CW]);
    endfunction

    // Present one pair and hold it until the block takes it. Returns at the
    // accepting edge, so the next call can drive straight away.
    task automatic send_pair(input pair_t p);
        if (allow_gaps && $urandom_range(0, 99) < 3) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_first_kind     <= p.first_kind;
        i_second_kind    <= p.second_kind;
        i_first_x        <= p.first_c[0];
        i_first_y        <= p.first_c[1];
        i_first_z        <= p.first_c[2];
        i_second_x       <= p.second_c[0];
        i_second_y       <= p.second_c[1];
        i_second_z       <= p.second_c[2];
        i_first_extents  <= p.first_ext;
        i_second_extents <= p.second_ext;
        do
            @(posedge i_clk);
        while (busy);
    endtask

    // Every ordered pair of kind codes on two overlapping primitives, so each
    // test fires (box-sphere twice) and noclip or the reserved code on either side drops it.
    task automatic test_kind_matrix();
        logic [1:0] kinds [4];
        kinds = '{KIND_NOCLIP, KIND_SPHERE, KIND_BOX, KIND_RESERVED};
        foreach (kinds[a])
            foreach (kinds[b])
                send_pair(make_pair(kinds[a], kinds[b], '{0, 0, 0}, '{256, 256, 256},
                                    '{128, 0, 0}, '{256, 256, 256}));
    endtask

    task automatic test_boundaries();
        // Spheres touching: distance equals the radius sum, still a hit.
        send_pair(make_pair(KIND_SPHERE, KIND_SPHERE, '{0, 0, 0}, '{300, 0, 0},
                            '{500, 0, 0}, '{200, 0, 0}));
        // One step further apart: no hit.
        send_pair(make_pair(KIND_SPHERE, KIND_SPHERE, '{0, 0, 0}, '{300, 0, 0},
                            '{501, 0, 0}, '{200, 0, 0}));
        // Boxes sharing a face only: no hit.
        send_pair(make_pair(KIND_BOX, KIND_BOX, '{0, 0, 0}, '{100, 100, 100},
                            '{200, 0, 0}, '{100, 100, 100}));
        // Box flattened to zero thickness on x, centred in the other box.
        send_pair(make_pair(KIND_BOX, KIND_BOX, '{0, 0, 0}, '{0, 100, 100},
                            '{0, 0, 0}, '{100, 100, 100}));
        // Sphere whose surface just reaches a box face.
        send_pair(make_pair(KIND_BOX, KIND_SPHERE, '{0, 0, 0}, '{100, 100, 100},
                            '{300, 0, 0}, '{200, 0, 0}));
        // Sphere first, reaching a box edge along a 3-4-5 diagonal.
        send_pair(make_pair(KIND_SPHERE, KIND_BOX, '{160, 180, 0}, '{100, 0, 0},
                            '{0, 0, 0}, '{100, 100, 100}));
    endtask

    task automatic test_extremes();
        send_pair(make_pair(KIND_SPHERE, KIND_SPHERE,
                            '{COORD_MIN, COORD_MIN, COORD_MIN}, '{EXT_MAX, EXT_MAX, EXT_MAX},
                            '{COORD_MAX, COORD_MAX, COORD_MAX}, '{EXT_MAX, EXT_MAX, EXT_MAX}));
        send_pair(make_pair(KIND_BOX, KIND_BOX,
                            '{COORD_MIN, COORD_MIN, COORD_MIN}, '{EXT_MAX, EXT_MAX, EXT_MAX},
                            '{COORD_MAX, COORD_MAX, COORD_MAX}, '{EXT_MAX, EXT_MAX, EXT_MAX}));
        send_pair(make_pair(KIND_BOX, KIND_SPHERE,
                            '{COORD_MIN, COORD_MIN, COORD_MIN}, '{0, 0, 0},
                            '{COORD_MAX, COORD_MAX, COORD_MAX}, '{0, 0, 0}));
    endtask

    // Pairs placed close together at a random scale so hits and misses both
    // come often; some are put exactly in contact along one axis and then
    // nudged by at most one step.
    task automatic test_near_pairs(input int count);
        pair_t p;
        int    scale;
        int    base;
        int    ax;
        int    reach;
        for (int i = 0; i < count; i++) begin
            allow_gaps = (i >= QUIET_PAIRS);
            p.first_kind = pick_kind();
            p.second_kind = pick_kind();
            scale = 1 << $urandom_range(1, 13);
            for (int k = 0; k < 3; k++) begin
                base = int'($urandom_range(0, EXT_MAX)) + COORD_MIN;
                p.first_c[k] = coord_t'(base);
                p.second_c[k] = sat_coord(base + int'($urandom_range(0, 2 * scale)) - scale);
                p.first_ext[k*CW +: CW] = CW'($urandom_range(0, scale));
                p.second_ext[k*CW +: CW] = CW'($urandom_range(0, scale));
            end
            if ($urandom_range(0, 99) < 15) begin
                ax = $urandom_range(0, 2);
                reach = reach_along(p.first_kind, p.first_ext, ax)
                      + reach_along(p.second_kind, p.second_ext, ax)
                      + int'($urandom_range(0, 2)) - 1;
                p.second_c = p.first_c;
                p.second_c[ax] = sat_coord(int'(p.first_c[ax])
                                           + ($urandom_range(0, 1) ? reach : -reach));
            end
            send_pair(p);
        end
    endtask

    // Unconstrained fields: every bit of every field, and kind code 3.
    task automatic test_wide_pairs(input int count);
        pair_t p;
        for (int i = 0; i < count; i++) begin
            p.first_kind = 2'($urandom_range(0, 3));
            p.second_kind = 2'($urandom_range(0, 3));
            for (int k = 0; k < 3; k++) begin
                p.first_c[k] = coord_t'($urandom);
                p.second_c[k] = coord_t'($urandom);
            end
            p.first_ext = extents_t'({$urandom, $urandom});
            p.second_ext = extents_t'({$urandom, $urandom});
            send_pair(p);
        end
    endtask

    // Scoreboard: log each accepted pair with its predicted hit, then match
    // each result beat against the oldest entry. Push before check so the
    // ordering holds even if a result came back in the accepting cycle.
    always @(posedge i_clk) begin
        pair_t     seen;
        hit_note_t want;
        if (!i_rst_n) begin
            stall_cycles = 0;
        end else begin
            if (start && !busy) begin
                seen.first_kind  = i_first_kind;
                seen.second_kind = i_second_kind;
                seen.first_c     = '{i_first_x, i_first_y, i_first_z};
                seen.second_c    = '{i_second_x, i_second_y, i_second_z};
                seen.first_ext   = i_first_extents;
                seen.second_ext  = i_second_extents;
                expected_hits.push_back('{hit: predict_hit(seen), index: pairs_sent});
                test_count[pair_test(i_first_kind, i_second_kind)]++;
                pairs_sent++;
            end
            if (o_valid) begin
                results_seen++;
                if (o_hit === 1'b1)
                    hits_seen++;
                if (expected_hits.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: result beat with no pair outstanding, hit %b",
                                 $time, o_hit);
                end else begin
                    want = expected_hits.pop_front();
                    if (o_hit !== want.hit) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: pair %0d hit mismatch, expected %b actual %b",
                                     $time, want.index, want.hit, o_hit);
                    end
                end
            end
            if ((start && !busy) || o_valid)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // Watchdog: end the run when no beat moves for too long.
    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, expected_hits.size());
        $display("primitive_collision_test regression: fail");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_kind_matrix();
        test_boundaries();
        test_extremes();
        test_near_pairs(NEAR_PAIRS);
        test_wide_pairs(WIDE_PAIRS);

        // Drop start at the last accepting edge, then drain the pipeline.
        start <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d pairs: %0d sphere-sphere, %0d box-box, %0d box-sphere, %0d untested",
                 pairs_sent, test_count[PAIR_SS], test_count[PAIR_BB], test_count[PAIR_BS],
                 test_count[PAIR_NONE]);
        $display("Checked %0d results (%0d hits), %0d mismatches",
                 results_seen, hits_seen, mismatch_count);
        if (mismatch_count == 0 && expected_hits.size() == 0)
            $display("primitive_collision_test regression: pass");
        else
            $display("primitive_collision_test regression: fail");
        $finish;
    end

endmodule
